[rtl/cotp_pkg.sv]
// Shared types and constants for the chunk offset table patcher.
package cotp_pkg;

   // Result queue: holds two full co64 entry bursts.
   localparam int QDEPTH = 16;
   localparam int QAW    = $clog2(QDEPTH);
   localparam int QCW    = QAW + 1;
   localparam int BURST_MAX = 8;

   localparam logic [3:0] NARROW_BYTES = 4'd4;
   localparam logic [3:0] WIDE_BYTES   = 4'd8;

   localparam logic [31:0] MOOV_LENGTH_RESET = 32'd16;
   localparam logic [31:0] CMOV_POSITION     = 32'd15;
   localparam logic [31:0] SCAN_FIRST_POS    = 32'd7;

   localparam logic [31:0] TYPE_STCO = 32'h7374_636F;
   localparam logic [31:0] TYPE_CO64 = 32'h636F_3634;
   localparam logic [31:0] TYPE_CMOV = 32'h636D_6F76;

   localparam logic [1:0] ERR_NONE        = 2'd0;
   localparam logic [1:0] ERR_ATOM_SIZE   = 2'd1;
   localparam logic [1:0] ERR_ENTRY_COUNT = 2'd2;
   localparam logic [1:0] ERR_COMPRESSED  = 2'd3;

   localparam logic [2:0] HEADER_LAST_INDEX = 3'd7;

   typedef enum logic [1:0] {
      MODE_SCAN,
      MODE_HEADER,
      MODE_ENTRY,
      MODE_DEAD
   } mode_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic [1:0] error_code;
   } rsp_entry_type;

endpackage

[rtl/chunk_offset_table_patcher.sv]
// Streaming stco/co64 chunk offset patcher for the bytes of a moov atom.
//
// Usage: feed the moov atom one byte per beat on req_* (valid/ready). Each
// byte leaves on rsp_* in file order; chunk offset entries are held until
// complete and then leave as a burst of 4 (stco) or 8 (co64) patched bytes,
// each entry increased by the moov length written on csr_*. rsp_out_last
// marks moov byte moov_length-1. On a bad atom size, bad entry count or a
// compressed moov, one result with a nonzero error code is given per byte
// from then on, until the moov end returns the block to its start state.
// A result beat enters the result queue as its byte is taken and is offered from its head in order.
// Throughput: one byte per cycle sustained. A byte is taken when the
// 16-entry result queue has room for every result it can cause, so an
// 8-byte entry burst drains while the next entry is collected. When the
// receiver stalls, the queue fills and req_ready drops; nothing is lost.
// Reset (synchronous) empties the queue, clears the scan state and sets
// the moov length to 16. Write the moov length only while the block idles.
module chunk_offset_table_patcher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last,
   output logic [1:0]  rsp_error_code,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);
   import cotp_pkg::*;

   logic [31:0] moov_length_ff;
   logic [31:0] byte_pos_ff, byte_pos_in;
   logic [31:0] type_win_ff, type_win_in;
   logic [31:0] size_win_ff, size_win_in;
   mode_type    mode_ff, mode_in;
   logic        wide_ff, wide_in;
   logic [31:0] entries_ff, entries_in;
   logic [31:0] table_end_ff, table_end_in;
   logic [63:0] entry_ff, entry_in;
   logic [2:0]  ebi_ff, ebi_in;
   logic [1:0]  err_latched_ff, err_latched_in;

   rsp_entry_type q_ff [QDEPTH];
   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0] q_count_ff, q_count_in;

   logic           accept, pop;
   logic [3:0]     n_need;
   rsp_entry_type  res [BURST_MAX];
   logic [1:0]     step_err;

   logic [32:0] pos_next, len33;
   logic        last_byte;
   logic [31:0] tw, sw;
   logic [63:0] entry_shift, sum64;
   logic [2:0]  ebi_inc;
   logic        entry_done;
   logic [31:0] cnt_shift;
   logic [34:0] cnt_need;
   logic [35:0] cnt_end;
   logic        cnt_bad;
   logic [31:0] i_pos;
   logic        scan_hit;
   logic [33:0] tab_end;
   logic        size_bad;
   logic [32:0] hdr_end;
   logic        hdr_bad;
   logic        cmov_hit;

   assign accept = req_valid && req_ready;
   assign pop    = rsp_valid && rsp_ready;

   assign pos_next  = {1'b0, byte_pos_ff} + 33'd1;
   assign len33     = {1'b0, moov_length_ff};
   assign last_byte = (pos_next == len33);

   assign tw = {type_win_ff[23:0], req_in_byte};
   assign sw = {size_win_ff[23:0], type_win_ff[31:24]};

   assign entry_shift = {entry_ff[55:0], req_in_byte};
   assign ebi_inc     = ebi_ff + 3'd1;
   assign entry_done  = wide_ff ? (ebi_inc == WIDE_BYTES[2:0]) : (ebi_inc == NARROW_BYTES[2:0]);
   assign sum64       = entry_shift + {32'd0, moov_length_ff};

   // Count bytes arrive in the second half of the header.
   assign cnt_shift = ebi_ff[2] ? {entries_ff[23:0], req_in_byte} : entries_ff;
   assign cnt_need  = wide_ff ? {cnt_shift, 3'b000} : {1'b0, cnt_shift, 2'b00};
   assign cnt_end   = {3'b000, pos_next} + {1'b0, cnt_need};
   assign cnt_bad   = cnt_end > {4'd0, moov_length_ff};

   assign i_pos    = byte_pos_ff - 32'd3;
   assign scan_hit = (byte_pos_ff >= SCAN_FIRST_POS) && (pos_next < len33)
                     && (i_pos > table_end_ff) && ((tw == TYPE_STCO) || (tw == TYPE_CO64));
   assign tab_end  = {2'b00, i_pos} + {2'b00, sw} - 34'd4;
   assign size_bad = tab_end > {2'b00, moov_length_ff};
   assign hdr_end  = {1'b0, i_pos} + 33'd12;
   assign hdr_bad  = hdr_end > len33;
   assign cmov_hit = (byte_pos_ff == CMOV_POSITION) && (tw == TYPE_CMOV);

   always_comb begin
      step_err = ERR_NONE;
      case (mode_ff)
         MODE_SCAN: begin
            if (cmov_hit) begin
               step_err = ERR_COMPRESSED;
            end else if (scan_hit && size_bad) begin
               step_err = ERR_ATOM_SIZE;
            end else if (scan_hit && hdr_bad) begin
               step_err = ERR_ENTRY_COUNT;
            end
         end
         MODE_HEADER: begin
            if (ebi_ff == HEADER_LAST_INDEX && cnt_bad) begin
               step_err = ERR_ENTRY_COUNT;
            end
         end
         default: step_err = ERR_NONE;
      endcase
   end

   // Next state of the scanner.
   always_comb begin
      byte_pos_in    = byte_pos_ff;
      type_win_in    = type_win_ff;
      size_win_in    = size_win_ff;
      mode_in        = mode_ff;
      wide_in        = wide_ff;
      entries_in     = entries_ff;
      table_end_in   = table_end_ff;
      entry_in       = entry_ff;
      ebi_in         = ebi_ff;
      err_latched_in = err_latched_ff;
      if (accept) begin
         case (mode_ff)
            MODE_ENTRY: begin
               entry_in = entry_shift;
               ebi_in   = ebi_inc;
               if (entry_done) begin
                  // Windows end on the last bytes of the patched burst.
                  size_win_in = wide_ff ? sum64[63:32] : type_win_ff;
                  type_win_in = sum64[31:0];
                  entry_in    = 64'd0;
                  ebi_in      = 3'd0;
                  entries_in  = entries_ff - 32'd1;
                  if (entries_ff == 32'd1) begin
                     mode_in = MODE_SCAN;
                  end
               end
            end
            MODE_HEADER: begin
               if (ebi_ff == HEADER_LAST_INDEX) begin
                  if (!cnt_bad) begin
                     entries_in = cnt_shift;
                     ebi_in     = 3'd0;
                     entry_in   = 64'd0;
                     mode_in    = (cnt_shift == 32'd0) ? MODE_SCAN : MODE_ENTRY;
                  end
               end else begin
                  entries_in = cnt_shift;
                  ebi_in     = ebi_inc;
               end
               if (step_err == ERR_NONE) begin
                  size_win_in = sw;
                  type_win_in = tw;
               end
            end
            MODE_SCAN: begin
               if (step_err == ERR_NONE) begin
                  if (scan_hit) begin
                     wide_in      = (tw == TYPE_CO64);
                     table_end_in = tab_end[31:0];
                     entries_in   = 32'd0;
                     ebi_in       = 3'd0;
                     mode_in      = MODE_HEADER;
                  end
                  size_win_in = sw;
                  type_win_in = tw;
               end
            end
            default: begin
            end
         endcase
         if (step_err != ERR_NONE) begin
            err_latched_in = step_err;
            mode_in        = MODE_DEAD;
         end
         byte_pos_in = pos_next[31:0];
         if (last_byte) begin
            byte_pos_in    = 32'd0;
            type_win_in    = 32'd0;
            size_win_in    = 32'd0;
            mode_in        = MODE_SCAN;
            wide_in        = 1'b0;
            entries_in     = 32'd0;
            table_end_in   = 32'd0;
            entry_in       = 64'd0;
            ebi_in         = 3'd0;
            err_latched_in = ERR_NONE;
         end
      end
   end

   // Result beats caused by the byte on the input.
   always_comb begin
      n_need = 4'd0;
      for (int k = 0; k < BURST_MAX; k++) begin
         res[k] = '{out_byte: 8'd0, out_last: 1'b0, error_code: ERR_NONE};
      end
      case (mode_ff)
         MODE_DEAD: begin
            n_need = 4'd1;
            res[0] = '{out_byte: 8'd0, out_last: last_byte, error_code: err_latched_ff};
         end
         MODE_ENTRY: begin
            if (entry_done) begin
               n_need = wide_ff ? WIDE_BYTES : NARROW_BYTES;
               for (int k = 0; k < BURST_MAX; k++) begin
                  if (wide_ff) begin
                     res[k].out_byte = sum64[8*(7-k) +: 8];
                     res[k].out_last = last_byte && (k == BURST_MAX - 1);
                  end else if (k < 4) begin
                     res[k].out_byte = sum64[8*(3-k) +: 8];
                     res[k].out_last = last_byte && (k == 3);
                  end
               end
            end
         end
         default: begin
            n_need = 4'd1;
            if (step_err != ERR_NONE) begin
               res[0] = '{out_byte: 8'd0, out_last: last_byte, error_code: step_err};
            end else begin
               res[0] = '{out_byte: req_in_byte, out_last: last_byte, error_code: ERR_NONE};
            end
         end
      endcase
   end

   // Take a byte only when the queue can hold all of its results.
   assign req_ready = ({1'b0, q_count_ff} + {2'b00, n_need}) <= (QCW+1)'(QDEPTH);

   assign wr_ptr_in  = accept ? wr_ptr_ff + n_need[QAW-1:0] : wr_ptr_ff;
   assign rd_ptr_in  = pop ? rd_ptr_ff + QAW'(1) : rd_ptr_ff;
   assign q_count_in = q_count_ff + (accept ? {1'b0, n_need} : QCW'(0)) - QCW'(pop);

   assign rsp_valid      = (q_count_ff != QCW'(0));
   assign rsp_out_byte   = q_ff[rd_ptr_ff].out_byte;
   assign rsp_out_last   = q_ff[rd_ptr_ff].out_last;
   assign rsp_error_code = q_ff[rd_ptr_ff].error_code;

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int k = 0; k < BURST_MAX; k++) begin
            if (k < n_need) begin
               q_ff[wr_ptr_ff + QAW'(k)] <= res[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         moov_length_ff <= MOOV_LENGTH_RESET;
         byte_pos_ff    <= 32'd0;
         type_win_ff    <= 32'd0;
         size_win_ff    <= 32'd0;
         mode_ff        <= MODE_SCAN;
         wide_ff        <= 1'b0;
         entries_ff     <= 32'd0;
         table_end_ff   <= 32'd0;
         entry_ff       <= 64'd0;
         ebi_ff         <= 3'd0;
         err_latched_ff <= ERR_NONE;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         q_count_ff     <= '0;
      end else begin
         if (csr_write_enable) begin
            moov_length_ff <= csr_write_data;
         end
         byte_pos_ff    <= byte_pos_in;
         type_win_ff    <= type_win_in;
         size_win_ff    <= size_win_in;
         mode_ff        <= mode_in;
         wide_ff        <= wide_in;
         entries_ff     <= entries_in;
         table_end_ff   <= table_end_in;
         entry_ff       <= entry_in;
         ebi_ff         <= ebi_in;
         err_latched_ff <= err_latched_in;
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         q_count_ff     <= q_count_in;
      end
   end

`ifndef SYNTH
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count_ff <= QCW'(QDEPTH))
      else $error("result queue over capacity");

   a_dead_gives_beat: assert property (@(posedge clock) disable iff (reset)
      accept && mode_ff == MODE_DEAD |=> rsp_valid)
      else $error("byte in error state produced no result beat");

   a_moov_end_restart: assert property (@(posedge clock) disable iff (reset)
      accept && last_byte |=> byte_pos_ff == 32'd0 && mode_ff == MODE_SCAN
                              && err_latched_ff == ERR_NONE)
      else $error("scanner not restarted after moov end");

   a_error_beat_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != ERR_NONE |-> rsp_out_byte == 8'd0)
      else $error("error beat carries a data byte");
`endif

endmodule

[test/chunk_offset_table_patcher_checker.sv]
`timescale 1ns / 1ps
// Checker for the chunk offset table patcher: byte-stream predictor and result scoreboard.
module chunk_offset_table_patcher_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_out_last,
   input  logic [1:0]  rsp_error_code,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   output int          fail_count,
   output int          pending,
   output int          bytes_in,
   output int          beats_out,
   output int          error_beats,
   output int          offsets_patched
);
   import cotp_pkg::*;

   localparam int PRINT_CAP = 40;

   // shadow of the patcher state
   logic [31:0]   moov_length_cfg;
   logic [31:0]   byte_pos;
   logic [31:0]   type_win;
   logic [31:0]   size_win;
   logic [31:0]   entries_left;
   logic [31:0]   table_end;
   mode_type      mode;
   logic          wide;
   logic [63:0]   entry_acc;
   logic [2:0]    entry_idx;
   logic [1:0]    held_error;

   rsp_entry_type patched_beats[$];
   int            fails = 0;
   int            seen_in = 0;
   int            seen_out = 0;
   int            seen_err = 0;
   int            patched = 0;

   function void restart_scan();
      byte_pos     = '0;
      type_win     = '0;
      size_win     = '0;
      mode         = MODE_SCAN;
      wide         = 1'b0;
      entries_left = '0;
      table_end    = '0;
      entry_acc    = '0;
      entry_idx    = '0;
      held_error   = ERR_NONE;
   endfunction

   // shift the emitted byte through the windows and queue it
   function void emit_beat(input logic [7:0] b, input logic last);
      size_win = {size_win[23:0], type_win[31:24]};
      type_win = {type_win[23:0], b};
      patched_beats.push_back({b, last, ERR_NONE});
   endfunction

   function void predict_byte(input logic [7:0] b);
      logic [31:0] p;
      logic [31:0] tw;
      logic [31:0] sw;
      logic [31:0] cnt;
      logic [63:0] len64;
      logic [63:0] sum;
      logic [63:0] start;
      logic [63:0] reach;
      logic [3:0]  w;
      logic [1:0]  err;
      logic        last;
      int          k;
      p     = byte_pos;
      len64 = {32'd0, moov_length_cfg};
      last  = ({32'd0, p} + 64'd1 == len64);
      err   = ERR_NONE;
      w     = wide ? WIDE_BYTES : NARROW_BYTES;
      case (mode)
         MODE_DEAD: begin
            patched_beats.push_back({8'h00, last, held_error});
         end
         MODE_ENTRY: begin
            entry_acc = {entry_acc[55:0], b};
            entry_idx = entry_idx + 3'd1;
            // a co64 entry completes when the 3-bit index wraps to zero
            if (entry_idx == w[2:0]) begin
               sum = entry_acc + {32'd0, moov_length_cfg};
               if (!wide)
                  sum[63:32] = '0;
               for (k = int'(w) - 1; k >= 0; k--)
                  emit_beat(sum[8*k +: 8], last && k == 0);
               entry_acc    = '0;
               entry_idx    = '0;
               patched++;
               entries_left = entries_left - 32'd1;
               if (entries_left == 0)
                  mode = MODE_SCAN;
            end
         end
         MODE_HEADER: begin
            cnt = entries_left;
            if (entry_idx >= 3'd4)
               cnt = {cnt[23:0], b};
            if (entry_idx == HEADER_LAST_INDEX) begin
               if ({32'd0, p} + 64'd1 + {32'd0, cnt} * {60'd0, w} > len64) begin
                  err = ERR_ENTRY_COUNT;
               end else begin
                  entries_left = cnt;
                  entry_idx    = '0;
                  entry_acc    = '0;
                  mode         = (cnt == 0) ? MODE_SCAN : MODE_ENTRY;
               end
            end else begin
               entries_left = cnt;
               entry_idx    = entry_idx + 3'd1;
            end
            if (err == ERR_NONE)
               emit_beat(b, last);
         end
         default: begin
            tw    = {type_win[23:0], b};
            sw    = {size_win[23:0], type_win[31:24]};
            start = {32'd0, p - 32'd3};
            reach = start + {32'd0, sw} - 64'd4;
            if (p == CMOV_POSITION && tw == TYPE_CMOV) begin
               err = ERR_COMPRESSED;
            end else if (p >= SCAN_FIRST_POS && start + 64'd4 < len64
                         && p - 32'd3 > table_end
                         && (tw == TYPE_STCO || tw == TYPE_CO64)) begin
               if (reach > len64) begin
                  err = ERR_ATOM_SIZE;
               end else if (start + 64'd12 > len64) begin
                  err = ERR_ENTRY_COUNT;
               end else begin
                  wide         = (tw == TYPE_CO64);
                  table_end    = reach[31:0];
                  entries_left = '0;
                  entry_idx    = '0;
                  mode         = MODE_HEADER;
               end
            end
            if (err == ERR_NONE)
               emit_beat(b, last);
         end
      endcase
      if (err != ERR_NONE) begin
         held_error = err;
         mode       = MODE_DEAD;
         patched_beats.push_back({8'h00, last, err});
      end
      byte_pos = p + 32'd1;
      if (last)
         restart_scan();
   endfunction

   task automatic report_mismatch(input string what, input rsp_entry_type got,
                                  input rsp_entry_type want);
      if (fails < PRINT_CAP)
         $display("MISMATCH %0t ns beat %0d %s: got byte %02h last %0b err %0d, want byte %02h last %0b err %0d",
                  $time, seen_out, what, got.out_byte, got.out_last, got.error_code,
                  want.out_byte, want.out_last, want.error_code);
      fails++;
   endtask

   task automatic compare_beat();
      rsp_entry_type got;
      rsp_entry_type want;
      got = {rsp_out_byte, rsp_out_last, rsp_error_code};
      seen_out++;
      if (got.error_code != ERR_NONE)
         seen_err++;
      if (patched_beats.size() == 0) begin
         report_mismatch("with nothing expected", got, got);
      end else begin
         want = patched_beats.pop_front();
         if (got.out_byte !== want.out_byte)
            report_mismatch("out_byte", got, want);
         if (got.out_last !== want.out_last)
            report_mismatch("out_last", got, want);
         if (got.error_code !== want.error_code)
            report_mismatch("error_code", got, want);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         moov_length_cfg = MOOV_LENGTH_RESET;
         restart_scan();
         patched_beats.delete();
      end else begin
         if (csr_write_enable)
            moov_length_cfg = csr_write_data;
         if (req_valid && req_ready) begin
            seen_in++;
            predict_byte(req_in_byte);
         end
         if (rsp_valid && rsp_ready)
            compare_beat();
      end
      // publish through nonblocking updates so the stimulus side reads settled values
      fail_count      <= fails;
      pending         <= patched_beats.size();
      bytes_in        <= seen_in;
      beats_out       <= seen_out;
      error_beats     <= seen_err;
      offsets_patched <= patched;
   end

endmodule

[test/chunk_offset_table_patcher_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the chunk offset table patcher: moov stimulus, handshakes and verdict.
module chunk_offset_table_patcher_tb;
   import cotp_pkg::*;

   localparam int          RANDOM_ITEMS = 350;
   localparam int          CALM_TAIL    = 60;
   localparam longint      LIMIT_NS     = 64'd16_000_000;
   localparam logic [31:0] TYPE_MOOV    = 32'h6D6F_6F76;
   localparam logic [31:0] LENGTH_MAX   = 32'hFFFF_FFFF;

   typedef enum int {
      FLAW_NONE,
      FLAW_SIZE,
      FLAW_COUNT
   } flaw_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_out_last;
   logic [1:0]  rsp_error_code;
   logic        csr_write_enable = 1'b0;
   logic [31:0] csr_write_data = 32'd0;

   int fail_count;
   int pending;
   int bytes_in;
   int beats_out;
   int error_beats;
   int offsets_patched;

   logic [7:0]  moov_image[$];
   logic [31:0] moov_len = MOOV_LENGTH_RESET;
   logic [31:0] moov_pos = '0;
   logic        calm = 1'b0;
   int          sent = 0;
   int          moovs = 0;

   chunk_offset_table_patcher dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_last     (rsp_out_last),
      .rsp_error_code   (rsp_error_code),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   chunk_offset_table_patcher_checker offset_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_last     (rsp_out_last),
      .rsp_error_code   (rsp_error_code),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending          (pending),
      .bytes_in         (bytes_in),
      .beats_out        (beats_out),
      .error_beats      (error_beats),
      .offsets_patched  (offsets_patched)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // receiver: ready in random runs, with stalls between them unless calm
   initial begin
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
         if (!calm) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
      if ({1'b0, moov_pos} + 33'd1 == {1'b0, moov_len})
         moov_pos = '0;
      else
         moov_pos = moov_pos + 32'd1;
   endtask

   task automatic send_image();
      foreach (moov_image[k])
         send_byte(moov_image[k]);
      moovs++;
   endtask

   // drop valid, drain every expected beat, then cover beats with no result
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_length(input logic [31:0] v);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      moov_len = v;
   endtask

   task automatic put_word(input logic [31:0] v);
      moov_image.push_back(v[31:24]);
      moov_image.push_back(v[23:16]);
      moov_image.push_back(v[15:8]);
      moov_image.push_back(v[7:0]);
   endtask

   task automatic put_filler(input int n);
      repeat (n) moov_image.push_back($urandom_range(0, 255));
   endtask

   task automatic put_table(input bit wide, input flaw_type flaw);
      int          cnt;
      int          pad;
      int          width;
      int          k;
      logic [63:0] v;
      width = wide ? 8 : 4;
      cnt   = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 4);
      pad   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
      if (flaw == FLAW_SIZE)
         put_word(32'hFFFF_0000 | $urandom_range(0, 65535));
      else
         put_word(16 + cnt * width + pad);
      put_word(wide ? TYPE_CO64 : TYPE_STCO);
      put_word($urandom);
      if (flaw == FLAW_COUNT)
         put_word(32'h0001_0000 + $urandom_range(0, 255));
      else
         put_word(cnt);
      repeat (cnt) begin
         case ($urandom_range(0, 3))
            0:       v = '1;
            1:       v = {TYPE_STCO, TYPE_CO64};
            default: v = {$urandom, $urandom};
         endcase
         for (k = width - 1; k >= 0; k--)
            moov_image.push_back(v[8*k +: 8]);
      end
      // a type code in the slack of a table must not open a new one
      if (pad >= 4) begin
         put_word(TYPE_STCO);
         pad = pad - 4;
      end
      put_filler(pad);
   endtask

   task automatic build_moov();
      int          k;
      logic [31:0] total;
      moov_image.delete();
      put_word(32'd0);
      put_word(TYPE_MOOV);
      if ($urandom_range(0, 11) == 0) begin
         put_word(32'd8 + $urandom_range(0, 64));
         put_word(TYPE_CMOV);
      end
      repeat ($urandom_range(1, 3)) begin
         case ($urandom_range(0, 11))
            0, 1:       put_filler($urandom_range(1, 12));
            2:          put_table($urandom_range(0, 1), FLAW_SIZE);
            3:          put_table($urandom_range(0, 1), FLAW_COUNT);
            4, 5, 6, 7: put_table(1'b0, FLAW_NONE);
            default:    put_table(1'b1, FLAW_NONE);
         endcase
      end
      // table header cut off by the moov end
      if ($urandom_range(0, 7) == 0) begin
         put_word(32'd8);
         put_word($urandom_range(0, 1) ? TYPE_CO64 : TYPE_STCO);
         put_filler($urandom_range(1, 7));
      end
      while (moov_image.size() < 16)
         moov_image.push_back($urandom_range(0, 255));
      total = moov_image.size();
      for (k = 0; k < 4; k++)
         moov_image[k] = total[8*(3-k) +: 8];
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: reset length, extreme byte values, compressed type on the final beat
      moov_image.delete();
      put_word(32'h0000_0010);
      put_word(TYPE_MOOV);
      put_word(32'hFF00_00FF);
      put_word(TYPE_CMOV);
      send_image();
      settle();

      // shortest legal moov, written explicitly
      moov_image.delete();
      put_filler(16);
      set_length(32'd16);
      send_image();
      settle();

      // largest length: no moov end, offsets wrap; then shorten it to close the moov
      build_moov();
      set_length(LENGTH_MAX);
      send_image();
      settle();
      set_length((moov_pos + 32'd1 < MOOV_LENGTH_RESET) ? MOOV_LENGTH_RESET
                                                        : moov_pos + 32'd1);
      while (moov_pos != 0)
         send_byte($urandom_range(0, 255));
      settle();

      while (sent < RANDOM_ITEMS) begin
         calm <= (sent > RANDOM_ITEMS - CALM_TAIL) || ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 5) == 0) begin
            moov_image.delete();
            put_filler($urandom_range(16, 40));
         end else begin
            build_moov();
         end
         set_length(moov_image.size());
         send_image();
         settle();
      end

      $display("Run covered %0d moov atoms, %0d bytes in, %0d result beats (%0d with an error code)",
               moovs, bytes_in, beats_out, error_beats);
      $display("and %0d chunk offsets patched across lengths from 16 to %0d",
               offsets_patched, LENGTH_MAX);
      if (fail_count == 0 && pending == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #(LIMIT_NS);
      $display("Timeout with %0d result beats still expected", pending);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
